/* design/prsl_pkg.sv */
// Shared types, constants and helpers of the polyline resampler.
package prsl_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int STEP_W  = 31;
  localparam int GUARD   = 12;
  localparam int ARITH_W = 128;
  localparam int HALF_W  = 64;
  localparam int SAT_W   = 64;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic signed [SAT_W-1:0] COORD_MAX = (SAT_W'(1) <<< (COORD_W - 1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] COORD_MIN = -COORD_MAX - SAT_W'(1);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t in_x;
    coord_t in_y;
    coord_t in_z;
    logic   final_vertex;
  } in_beat_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   point_valid;
    logic   run_end;
  } out_beat_t;

  typedef enum logic [1:0] {
    ARITH_MUL,
    ARITH_SQRT,
    ARITH_DIV
  } arith_op_t;

  typedef struct packed {
    logic                start;
    arith_op_t           op;
    logic [ARITH_W-1:0]  a;
    logic [HALF_W-1:0]   b;
  } arith_req_t;

  typedef struct packed {
    logic                done;
    logic [ARITH_W-1:0]  res;
  } arith_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DECIDE,
    ST_DIST,
    ST_FIN,
    ST_DONE,
    ST_SEG_MUL,
    ST_SEG_LEN,
    ST_SEG_PROJ,
    ST_SEG_PSQ,
    ST_SEG_DISC,
    ST_SEG_ROOT,
    ST_SEG_SCALE,
    ST_SEG_DIV,
    ST_SEG_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    CONT_FIRST_CHECK,
    CONT_AFTER_STEP,
    CONT_SECOND_CHECK,
    CONT_AFTER_SEG,
    CONT_FINAL_CHECK,
    CONT_AFTER_FINAL
  } cont_t;

  function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] v);
    coord_t r;
    if (v > COORD_MAX) begin
      r = COORD_W'(COORD_MAX);
    end else if (v < COORD_MIN) begin
      r = COORD_W'(COORD_MIN);
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

endpackage

/* design/prsl_fifo.sv */
// Register queue with first-word fall-through read and fill level.
module prsl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty,
  output logic [LW-1:0]    level
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [LW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == LW'(DEPTH));
  assign empty   = (count_r == '0);
  assign level   = count_r;
  assign rd_data = mem_r[rptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + LW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

/* design/prsl_arith.sv */
// Shared iterative arithmetic unit: split multiply, digit square root, restoring divide.
module prsl_arith (
  input  logic                 clk,
  input  logic                 rst_n,
  input  prsl_pkg::arith_req_t req,
  output prsl_pkg::arith_rsp_t rsp
);

  localparam int AW = prsl_pkg::ARITH_W;
  localparam int HW = prsl_pkg::HALF_W;
  localparam int QW = HW / 2;
  localparam int RW = HW + 3;
  localparam int CW = 7;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  prsl_pkg::arith_op_t op_r, op_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       x_r, x_nxt;
  logic [HW-1:0]       y_r, y_nxt;
  logic [AW-1:0]       acc_r, acc_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [AW-1:0]       res_r, res_nxt;

  logic [QW-1:0]       mul_a, mul_b;
  logic [HW-1:0]       mul_pp;
  logic [CW-1:0]       mul_sh;
  logic [AW-1:0]       mul_sum;
  logic [RW-1:0]       sq_rem_sh, sq_trial, sq_rem;
  logic                sq_ge;
  logic [HW:0]         dv_rem_sh, dv_rem;
  logic                dv_ge;
  logic                last;

  assign mul_a   = cnt_r[1] ? x_r[HW-1:QW] : x_r[QW-1:0];
  assign mul_b   = cnt_r[0] ? y_r[HW-1:QW] : y_r[QW-1:0];
  assign mul_pp  = mul_a * mul_b;
  assign mul_sh  = {cnt_r[1] & cnt_r[0], cnt_r[1] ^ cnt_r[0], 5'b0};
  assign mul_sum = acc_r + (AW'(mul_pp) << mul_sh);

  assign sq_rem_sh = {rem_r[RW-3:0], x_r[AW-1:AW-2]};
  assign sq_trial  = {1'b0, acc_r[HW-1:0], 2'b01};
  assign sq_ge     = (sq_rem_sh >= sq_trial);
  assign sq_rem    = sq_ge ? sq_rem_sh - sq_trial : sq_rem_sh;

  assign dv_rem_sh = {rem_r[HW-1:0], x_r[AW-1]};
  assign dv_ge     = (dv_rem_sh >= {1'b0, y_r});
  assign dv_rem    = dv_ge ? dv_rem_sh - {1'b0, y_r} : dv_rem_sh;

  always_comb begin
    unique case (op_r)
      prsl_pkg::ARITH_MUL:  last = (cnt_r == CW'(3));
      prsl_pkg::ARITH_SQRT: last = (cnt_r == CW'(HW - 1));
      prsl_pkg::ARITH_DIV:  last = (cnt_r == CW'(AW - 1));
      default:              last = 1'b1;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        op_nxt   = req.op;
        cnt_nxt  = '0;
        x_nxt    = req.a;
        y_nxt    = req.b;
        acc_nxt  = '0;
        rem_nxt  = '0;
      end
    end else begin
      unique case (op_r)
        prsl_pkg::ARITH_MUL: begin
          acc_nxt = mul_sum;
        end
        prsl_pkg::ARITH_SQRT: begin
          rem_nxt = sq_rem;
          acc_nxt = {{(AW-HW){1'b0}}, acc_r[HW-2:0], sq_ge};
          x_nxt   = x_r << 2;
        end
        prsl_pkg::ARITH_DIV: begin
          rem_nxt = {3'b0, dv_rem[HW-1:0]};
          acc_nxt = {{(AW-HW){1'b0}}, acc_r[HW-2:0], dv_ge};
          x_nxt   = x_r << 1;
        end
        default: begin
          acc_nxt = '0;
        end
      endcase
      cnt_nxt = cnt_r + CW'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

/* design/prsl_back.sv */
// Back end sequencer: duplicate test, distance tests, step and segment points, result beats.
module prsl_back #(
  parameter int OUT_DEPTH = prsl_pkg::OUT_DEPTH,
  localparam int LW = $clog2(OUT_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [prsl_pkg::STEP_W-1:0]   step_length,
  input  logic                          in_empty,
  input  prsl_pkg::in_beat_t            in_beat,
  output logic                          in_pop,
  input  logic [LW-1:0]                 out_level,
  output logic                          out_push,
  output prsl_pkg::out_beat_t           out_data,
  output prsl_pkg::arith_req_t          arith_req,
  input  prsl_pkg::arith_rsp_t          arith_rsp
);

  localparam int AW = prsl_pkg::ARITH_W;
  localparam int HW = prsl_pkg::HALF_W;
  localparam int DW = prsl_pkg::DIFF_W;
  localparam int SW = prsl_pkg::STEP_W;
  localparam int GS = 2 * prsl_pkg::GUARD;

  prsl_pkg::back_state_t state_r, state_nxt;
  prsl_pkg::cont_t       cont_r, cont_nxt;
  logic                  started_r, started_nxt;
  logic                  fin_r, fin_nxt;
  logic                  d2_sel_r, d2_sel_nxt;
  logic                  seg_fin_r, seg_fin_nxt;
  logic                  op_sent_r, op_sent_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [3:0]            k_r, k_nxt;

  prsl_pkg::coord_t      v_r [3], v_nxt [3];
  prsl_pkg::coord_t      prev_r [3], prev_nxt [3];
  prsl_pkg::coord_t      last_r [3], last_nxt [3];
  prsl_pkg::coord_t      res_r [3], res_nxt [3];
  prsl_pkg::out_beat_t   pend_r, pend_nxt;

  logic [AW-1:0]         s2_r, s2_nxt;
  logic [AW-1:0]         acc_r, acc_nxt;
  logic [AW-1:0]         alpha_r, alpha_nxt;
  logic [AW-1:0]         w2_r, w2_nxt;
  logic [AW-1:0]         dot_r, dot_nxt;
  logic [AW-1:0]         rad_r, rad_nxt;
  logic [HW-1:0]         len_r, len_nxt;
  logic [HW-1:0]         proj_r, proj_nxt;
  logic [HW-1:0]         tau_r, tau_nxt;

  logic [SW-1:0]         step_eff;
  prsl_pkg::coord_t      seg_p [3], seg_v [3], d2_b [3];
  logic signed [DW-1:0]  e [3], w [3], dd [3];
  logic [HW-1:0]         e_mag [3], w_mag [3], dd_mag [3];
  logic [1:0]            ki, gi;
  logic                  dot_neg;
  logic [AW-1:0]         dm, d2_sum, w2g, s2g, p2, prod;
  logic                  d2_gt, d2_gt4, prev_eq_last, v_eq_prev, room;
  logic [HW-1:0]         root, tau0;
  logic signed [prsl_pkg::SAT_W-1:0] dq, delta, moved;

  function automatic logic [HW-1:0] mag_diff(input logic signed [DW-1:0] d);
    logic [DW-1:0] u;
    u = d[DW-1] ? DW'(-d) : DW'(d);
    return HW'(u);
  endfunction

  assign step_eff = (step_length == '0) ? SW'(1) : step_length;
  assign ki       = k_r[1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      seg_p[i]  = seg_fin_r ? last_r[i] : prev_r[i];
      seg_v[i]  = seg_fin_r ? prev_r[i] : v_r[i];
      d2_b[i]   = d2_sel_r ? prev_r[i] : v_r[i];
      e[i]      = DW'(seg_v[i]) - DW'(seg_p[i]);
      w[i]      = DW'(seg_p[i]) - DW'(last_r[i]);
      dd[i]     = DW'(last_r[i]) - DW'(d2_b[i]);
      e_mag[i]  = mag_diff(e[i]);
      w_mag[i]  = mag_diff(w[i]);
      dd_mag[i] = mag_diff(dd[i]);
    end
  end

  always_comb begin
    if (k_r < 4'd3) begin
      gi = k_r[1:0];
    end else if (k_r < 4'd6) begin
      gi = 2'(k_r - 4'd3);
    end else begin
      gi = 2'(k_r - 4'd6);
    end
  end

  assign prod         = arith_rsp.res;
  assign dot_neg      = dot_r[AW-1];
  assign dm           = dot_neg ? -dot_r : dot_r;
  assign d2_sum       = acc_r + prod;
  assign d2_gt        = (d2_sum > s2_r);
  assign d2_gt4       = ((d2_sum << 2) > s2_r);
  assign w2g          = w2_r << GS;
  assign s2g          = s2_r << GS;
  assign p2           = prod;
  assign root         = prod[HW-1:0];
  assign tau0         = dot_neg ? root + proj_r : ((root > proj_r) ? root - proj_r : '0);
  assign dq           = $signed(prod[HW-1:0]);
  assign delta        = e[ki][DW-1] ? -dq : dq;
  assign moved        = prsl_pkg::SAT_W'(seg_p[ki]) + delta;
  assign prev_eq_last = (prev_r[0] == last_r[0]) && (prev_r[1] == last_r[1])
                        && (prev_r[2] == last_r[2]);
  assign v_eq_prev    = (v_r[0] == prev_r[0]) && (v_r[1] == prev_r[1])
                        && (v_r[2] == prev_r[2]);
  assign room         = (out_level <= LW'(OUT_DEPTH - 3));

  always_comb begin
    state_nxt      = state_r;
    cont_nxt       = cont_r;
    started_nxt    = started_r;
    fin_nxt        = fin_r;
    d2_sel_nxt     = d2_sel_r;
    seg_fin_nxt    = seg_fin_r;
    pend_valid_nxt = pend_valid_r;
    k_nxt          = k_r;
    v_nxt          = v_r;
    prev_nxt       = prev_r;
    last_nxt       = last_r;
    res_nxt        = res_r;
    pend_nxt       = pend_r;
    s2_nxt         = s2_r;
    acc_nxt        = acc_r;
    alpha_nxt      = alpha_r;
    w2_nxt         = w2_r;
    dot_nxt        = dot_r;
    rad_nxt        = rad_r;
    len_nxt        = len_r;
    proj_nxt       = proj_r;
    tau_nxt        = tau_r;
    in_pop         = 1'b0;
    out_push       = 1'b0;
    out_data       = pend_r;
    arith_req      = '0;
    arith_req.op   = prsl_pkg::ARITH_MUL;

    unique case (state_r)
      prsl_pkg::ST_SQUARE: begin
        arith_req.a = AW'(step_eff);
        arith_req.b = HW'(step_eff);
      end
      prsl_pkg::ST_DIST: begin
        arith_req.a = AW'(dd_mag[ki]);
        arith_req.b = dd_mag[ki];
      end
      prsl_pkg::ST_SEG_MUL: begin
        arith_req.a = AW'((k_r < 4'd3) ? e_mag[gi] : w_mag[gi]);
        arith_req.b = (k_r < 4'd6) ? ((k_r < 4'd3) ? e_mag[gi] : w_mag[gi]) : e_mag[gi];
        if (k_r >= 4'd6) begin
          arith_req.a = AW'(w_mag[gi]);
        end
      end
      prsl_pkg::ST_SEG_LEN: begin
        arith_req.op = prsl_pkg::ARITH_SQRT;
        arith_req.a  = alpha_r << GS;
      end
      prsl_pkg::ST_SEG_PROJ: begin
        arith_req.op = prsl_pkg::ARITH_DIV;
        arith_req.a  = dm << GS;
        arith_req.b  = len_r;
      end
      prsl_pkg::ST_SEG_PSQ: begin
        arith_req.a = AW'(proj_r);
        arith_req.b = proj_r;
      end
      prsl_pkg::ST_SEG_ROOT: begin
        arith_req.op = prsl_pkg::ARITH_SQRT;
        arith_req.a  = rad_r;
      end
      prsl_pkg::ST_SEG_SCALE: begin
        arith_req.a = AW'(e_mag[ki]);
        arith_req.b = tau_r;
      end
      prsl_pkg::ST_SEG_DIV: begin
        arith_req.op = prsl_pkg::ARITH_DIV;
        arith_req.a  = acc_r;
        arith_req.b  = len_r;
      end
      default: begin
        arith_req.a = '0;
      end
    endcase

    unique case (state_r)
      prsl_pkg::ST_SQUARE, prsl_pkg::ST_DIST, prsl_pkg::ST_SEG_MUL, prsl_pkg::ST_SEG_LEN,
      prsl_pkg::ST_SEG_PROJ, prsl_pkg::ST_SEG_PSQ, prsl_pkg::ST_SEG_ROOT,
      prsl_pkg::ST_SEG_SCALE, prsl_pkg::ST_SEG_DIV: begin
        arith_req.start = !op_sent_r;
      end
      default: begin
        arith_req.start = 1'b0;
      end
    endcase

    unique case (state_r)
      prsl_pkg::ST_IDLE: begin
        if (!in_empty && room) begin
          in_pop   = 1'b1;
          v_nxt[0] = in_beat.in_x;
          v_nxt[1] = in_beat.in_y;
          v_nxt[2] = in_beat.in_z;
          fin_nxt  = in_beat.final_vertex;
          state_nxt = prsl_pkg::ST_SQUARE;
        end
      end
      prsl_pkg::ST_SQUARE: begin
        if (arith_rsp.done) begin
          s2_nxt    = prod;
          state_nxt = prsl_pkg::ST_DECIDE;
        end
      end
      prsl_pkg::ST_DECIDE: begin
        if (!started_r) begin
          out_push       = pend_valid_r;
          pend_nxt       = '{out_x: v_r[0], out_y: v_r[1], out_z: v_r[2],
                             point_valid: 1'b1, run_end: 1'b0};
          pend_valid_nxt = 1'b1;
          prev_nxt       = v_r;
          last_nxt       = v_r;
          started_nxt    = 1'b1;
          state_nxt      = prsl_pkg::ST_FIN;
        end else if (!v_eq_prev) begin
          k_nxt      = '0;
          acc_nxt    = '0;
          d2_sel_nxt = 1'b0;
          cont_nxt   = prsl_pkg::CONT_FIRST_CHECK;
          state_nxt  = prsl_pkg::ST_DIST;
        end else begin
          state_nxt = prsl_pkg::ST_FIN;
        end
      end
      prsl_pkg::ST_DIST: begin
        if (arith_rsp.done) begin
          if (k_r == 4'd2) begin
            unique case (cont_r)
              prsl_pkg::CONT_FIRST_CHECK: begin
                if (d2_gt && prev_eq_last) begin
                  seg_fin_nxt = 1'b0;
                  cont_nxt    = prsl_pkg::CONT_AFTER_STEP;
                  state_nxt   = prsl_pkg::ST_SEG_MUL;
                end else if (d2_gt) begin
                  d2_sel_nxt = 1'b0;
                  cont_nxt   = prsl_pkg::CONT_SECOND_CHECK;
                  state_nxt  = prsl_pkg::ST_DIST;
                end else begin
                  prev_nxt  = v_r;
                  state_nxt = prsl_pkg::ST_FIN;
                end
              end
              prsl_pkg::CONT_SECOND_CHECK: begin
                if (d2_gt) begin
                  seg_fin_nxt = 1'b0;
                  cont_nxt    = prsl_pkg::CONT_AFTER_SEG;
                  state_nxt   = prsl_pkg::ST_SEG_MUL;
                end else begin
                  prev_nxt  = v_r;
                  state_nxt = prsl_pkg::ST_FIN;
                end
              end
              prsl_pkg::CONT_FINAL_CHECK: begin
                if (d2_gt4) begin
                  seg_fin_nxt = 1'b1;
                  cont_nxt    = prsl_pkg::CONT_AFTER_FINAL;
                  state_nxt   = prsl_pkg::ST_SEG_MUL;
                end else begin
                  state_nxt = prsl_pkg::ST_DONE;
                end
              end
              default: begin
                state_nxt = prsl_pkg::ST_DONE;
              end
            endcase
            k_nxt     = '0;
            acc_nxt   = '0;
            alpha_nxt = '0;
            w2_nxt    = '0;
            dot_nxt   = '0;
          end else begin
            acc_nxt = d2_sum;
            k_nxt   = k_r + 4'd1;
          end
        end
      end
      prsl_pkg::ST_FIN: begin
        if (fin_r) begin
          k_nxt      = '0;
          acc_nxt    = '0;
          d2_sel_nxt = 1'b1;
          cont_nxt   = prsl_pkg::CONT_FINAL_CHECK;
          state_nxt  = prsl_pkg::ST_DIST;
        end else begin
          state_nxt = prsl_pkg::ST_DONE;
        end
      end
      prsl_pkg::ST_DONE: begin
        out_push = pend_valid_r || fin_r;
        if (pend_valid_r) begin
          out_data         = pend_r;
          out_data.run_end = fin_r;
        end else begin
          out_data = '{out_x: '0, out_y: '0, out_z: '0, point_valid: 1'b0, run_end: 1'b1};
        end
        pend_valid_nxt = 1'b0;
        if (fin_r) begin
          started_nxt = 1'b0;
        end
        state_nxt = prsl_pkg::ST_IDLE;
      end
      prsl_pkg::ST_SEG_MUL: begin
        if (arith_rsp.done) begin
          if (k_r < 4'd3) begin
            alpha_nxt = alpha_r + prod;
          end else if (k_r < 4'd6) begin
            w2_nxt = w2_r + prod;
          end else begin
            dot_nxt = (e[gi][DW-1] != w[gi][DW-1]) ? dot_r - prod : dot_r + prod;
          end
          if (k_r == 4'd8) begin
            state_nxt = prsl_pkg::ST_SEG_LEN;
          end else begin
            k_nxt = k_r + 4'd1;
          end
        end
      end
      prsl_pkg::ST_SEG_LEN: begin
        if (arith_rsp.done) begin
          if (root == '0) begin
            res_nxt   = seg_p;
            state_nxt = prsl_pkg::ST_SEG_EMIT;
          end else begin
            len_nxt   = root;
            state_nxt = prsl_pkg::ST_SEG_PROJ;
          end
        end
      end
      prsl_pkg::ST_SEG_PROJ: begin
        if (arith_rsp.done) begin
          proj_nxt  = root;
          state_nxt = prsl_pkg::ST_SEG_PSQ;
        end
      end
      prsl_pkg::ST_SEG_PSQ: begin
        if (arith_rsp.done) begin
          rad_nxt   = (w2g > p2) ? w2g - p2 : '0;
          state_nxt = prsl_pkg::ST_SEG_DISC;
        end
      end
      prsl_pkg::ST_SEG_DISC: begin
        rad_nxt   = (s2g > rad_r) ? s2g - rad_r : '0;
        state_nxt = prsl_pkg::ST_SEG_ROOT;
      end
      prsl_pkg::ST_SEG_ROOT: begin
        if (arith_rsp.done) begin
          tau_nxt   = (!seg_fin_r && (tau0 > len_r)) ? len_r : tau0;
          k_nxt     = '0;
          state_nxt = prsl_pkg::ST_SEG_SCALE;
        end
      end
      prsl_pkg::ST_SEG_SCALE: begin
        if (arith_rsp.done) begin
          acc_nxt   = prod + AW'(len_r >> 1);
          state_nxt = prsl_pkg::ST_SEG_DIV;
        end
      end
      prsl_pkg::ST_SEG_DIV: begin
        if (arith_rsp.done) begin
          res_nxt[ki] = prsl_pkg::sat_coord(moved);
          if (k_r == 4'd2) begin
            state_nxt = prsl_pkg::ST_SEG_EMIT;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = prsl_pkg::ST_SEG_SCALE;
          end
        end
      end
      prsl_pkg::ST_SEG_EMIT: begin
        out_push       = pend_valid_r;
        pend_nxt       = '{out_x: res_r[0], out_y: res_r[1], out_z: res_r[2],
                           point_valid: 1'b1, run_end: 1'b0};
        pend_valid_nxt = 1'b1;
        last_nxt       = res_r;
        unique case (cont_r)
          prsl_pkg::CONT_AFTER_STEP: begin
            k_nxt      = '0;
            acc_nxt    = '0;
            d2_sel_nxt = 1'b0;
            cont_nxt   = prsl_pkg::CONT_SECOND_CHECK;
            state_nxt  = prsl_pkg::ST_DIST;
          end
          prsl_pkg::CONT_AFTER_SEG: begin
            prev_nxt  = v_r;
            state_nxt = prsl_pkg::ST_FIN;
          end
          default: begin
            state_nxt = prsl_pkg::ST_DONE;
          end
        endcase
      end
      default: begin
        state_nxt = prsl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    op_sent_nxt = op_sent_r;
    if (arith_req.start) begin
      op_sent_nxt = 1'b1;
    end else if (arith_rsp.done) begin
      op_sent_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= prsl_pkg::ST_IDLE;
      cont_r       <= prsl_pkg::CONT_FIRST_CHECK;
      started_r    <= 1'b0;
      fin_r        <= 1'b0;
      d2_sel_r     <= 1'b0;
      seg_fin_r    <= 1'b0;
      op_sent_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      k_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      cont_r       <= cont_nxt;
      started_r    <= started_nxt;
      fin_r        <= fin_nxt;
      d2_sel_r     <= d2_sel_nxt;
      seg_fin_r    <= seg_fin_nxt;
      op_sent_r    <= op_sent_nxt;
      pend_valid_r <= pend_valid_nxt;
      k_r          <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    prev_r  <= prev_nxt;
    last_r  <= last_nxt;
    res_r   <= res_nxt;
    pend_r  <= pend_nxt;
    s2_r    <= s2_nxt;
    acc_r   <= acc_nxt;
    alpha_r <= alpha_nxt;
    w2_r    <= w2_nxt;
    dot_r   <= dot_nxt;
    rad_r   <= rad_nxt;
    len_r   <= len_nxt;
    proj_r  <= proj_nxt;
    tau_r   <= tau_nxt;
  end

endmodule

/* design/polyline_resample_by_step_length.sv */
// Top level: input queue, back end sequencer, shared arithmetic unit, result queue.
// Vertices run one at a time, and each one waits on the shared arithmetic unit, which runs
// one multiply, root or divide at a time; a non-final first vertex is held as the pending beat
// and queued from the done state.
// Reset (synchronous, active low) empties both queues and sets step_length to 1.0.
module polyline_resample_by_step_length #(
  parameter int IN_DEPTH  = prsl_pkg::IN_DEPTH,
  parameter int OUT_DEPTH = prsl_pkg::OUT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  prsl_pkg::in_beat_t          in_beat,
  input  logic                        push,
  output logic                        full,
  output prsl_pkg::out_beat_t         out_beat,
  output logic                        empty,
  input  logic                        pop,
  input  logic                        cfg_we,
  input  logic [prsl_pkg::STEP_W-1:0] cfg_data
);

  localparam int IW  = $bits(prsl_pkg::in_beat_t);
  localparam int OW  = $bits(prsl_pkg::out_beat_t);
  localparam int ILW = $clog2(IN_DEPTH + 1);
  localparam int OLW = $clog2(OUT_DEPTH + 1);

  logic [prsl_pkg::STEP_W-1:0] step_r;
  logic [IW-1:0]               in_q_data;
  logic                        in_q_empty, in_q_pop;
  logic [ILW-1:0]              in_q_level;
  logic [OW-1:0]               out_q_data;
  logic [OLW-1:0]              out_q_level;
  logic                        out_q_full, out_push;
  prsl_pkg::out_beat_t         out_wdata;
  prsl_pkg::arith_req_t        arith_req;
  prsl_pkg::arith_rsp_t        arith_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= prsl_pkg::STEP_RESET;
    end else if (cfg_we) begin
      step_r <= cfg_data;
    end
  end

  prsl_fifo #(.WIDTH(IW), .DEPTH(IN_DEPTH)) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (in_beat),
    .rd_en   (in_q_pop),
    .rd_data (in_q_data),
    .full    (full),
    .empty   (in_q_empty),
    .level   (in_q_level)
  );

  prsl_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_length (step_r),
    .in_empty    (in_q_empty || (in_q_level == '0)),
    .in_beat     (prsl_pkg::in_beat_t'(in_q_data)),
    .in_pop      (in_q_pop),
    .out_level   (out_q_level),
    .out_push    (out_push),
    .out_data    (out_wdata),
    .arith_req   (arith_req),
    .arith_rsp   (arith_rsp)
  );

  prsl_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .rsp   (arith_rsp)
  );

  prsl_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_push),
    .wr_data (out_wdata),
    .rd_en   (pop),
    .rd_data (out_q_data),
    .full    (out_q_full),
    .empty   (empty),
    .level   (out_q_level)
  );

  assign out_beat = (out_q_full || !out_q_full) ? prsl_pkg::out_beat_t'(out_q_data) : '0;

endmodule

/* design/prsl_checker.sv */
// Port-level checker for the polyline resampler, bound to the top level.
module prsl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input prsl_pkg::out_beat_t out_beat
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_marker_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_beat.point_valid) |-> out_beat.run_end)
    else $error("end marker without run_end");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_beat.point_valid) |->
      (out_beat.out_x == '0) && (out_beat.out_y == '0) && (out_beat.out_z == '0))
    else $error("end marker carries coordinates");

  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_beat)))
    else $error("stalled result beat changed");

endmodule

bind polyline_resample_by_step_length prsl_checker u_prsl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_beat (out_beat)
);

/* tb/tb_polyline_resample_by_step_length.sv */
// Self-checking testbench for the polyline resampler: directed and random polylines against a scoreboard.
module tb_polyline_resample_by_step_length;

  localparam int DRAIN_CYCLES = 2600;

  logic                          clk;
  logic                          rst_n;
  prsl_pkg::in_beat_t            in_beat;
  logic                          push;
  logic                          full;
  prsl_pkg::out_beat_t           out_beat;
  logic                          empty;
  logic                          pop;
  logic                          cfg_we;
  logic [prsl_pkg::STEP_W-1:0]   cfg_data;
  int                            n_errors;
  bit                            gappy;

  polyline_resample_by_step_length u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat),
    .push     (push),
    .full     (full),
    .out_beat (out_beat),
    .empty    (empty),
    .pop      (pop),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    n_errors++;
  endtask

  class resample_scoreboard;
    longint                 kept[3];
    longint                 emitted[3];
    bit                     started;
    logic [63:0]            step;
    prsl_pkg::out_beat_t    pending_points[$];

    function new();
      kept    = '{0, 0, 0};
      emitted = '{0, 0, 0};
      started = 0;
      step    = 64'd65536;
    endfunction

    function void set_step(input logic [prsl_pkg::STEP_W-1:0] v);
      step = {33'd0, v};
    endfunction

    function logic [63:0] mag(input longint a);
      return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function logic [63:0] root(input logic [127:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= x) r = c;
      end
      return r;
    endfunction

    function logic [127:0] dist_sq(input longint a[3], input longint b[3]);
      logic [127:0] acc;
      logic [63:0]  d;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        d = mag(a[i] - b[i]);
        acc += {64'd0, d} * {64'd0, d};
      end
      return acc;
    endfunction

    function void step_point(input longint p[3], input longint v[3], input longint b[3],
                             input bit clip, output longint res[3]);
      longint                e[3];
      longint                w[3];
      logic [127:0]          alpha, w2, dm, q2, s2, rad, p2, w2g, m;
      logic signed [127:0]   dot;
      logic [63:0]           elen, proj, rt, tau, d;
      longint                t;
      alpha = '0;
      w2    = '0;
      dot   = '0;
      for (int i = 0; i < 3; i++) begin
        e[i] = v[i] - p[i];
        w[i] = p[i] - b[i];
        alpha += {64'd0, mag(e[i])} * {64'd0, mag(e[i])};
        w2    += {64'd0, mag(w[i])} * {64'd0, mag(w[i])};
        dot   += 128'(signed'(e[i])) * 128'(signed'(w[i]));
      end
      elen = root(alpha << (2 * prsl_pkg::GUARD));
      if (elen == 0) begin
        res = p;
        return;
      end
      dm   = dot[127] ? 128'(-dot) : 128'(dot);
      proj = 64'((dm << (2 * prsl_pkg::GUARD)) / {64'd0, elen});
      p2   = {64'd0, proj} * {64'd0, proj};
      w2g  = w2 << (2 * prsl_pkg::GUARD);
      q2   = (w2g > p2) ? w2g - p2 : '0;
      s2   = ({64'd0, step} * {64'd0, step}) << (2 * prsl_pkg::GUARD);
      rad  = (s2 > q2) ? s2 - q2 : '0;
      rt   = root(rad);
      if (dot[127]) tau = rt + proj;
      else tau = (rt > proj) ? rt - proj : '0;
      if (clip && tau > elen) tau = elen;
      for (int i = 0; i < 3; i++) begin
        m = {64'd0, mag(e[i])} * {64'd0, tau} + {64'd0, elen >> 1};
        d = 64'(m / {64'd0, elen});
        t = p[i] + ((e[i] < 0) ? -longint'(d) : longint'(d));
        if (t > 64'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
        else if (t < -64'sh8000_0000) t = -64'sh8000_0000;
        res[i] = t;
      end
    endfunction

    function void emit(input longint pt[3], ref prsl_pkg::out_beat_t q[$]);
      prsl_pkg::out_beat_t r;
      r.out_x       = prsl_pkg::coord_t'(pt[0]);
      r.out_y       = prsl_pkg::coord_t'(pt[1]);
      r.out_z       = prsl_pkg::coord_t'(pt[2]);
      r.point_valid = 1'b1;
      r.run_end     = 1'b0;
      q = {q, r};
    endfunction

    function void note_vertex(input prsl_pkg::in_beat_t b);
      longint                 v[3];
      longint                 np[3];
      logic [127:0]           s2;
      prsl_pkg::out_beat_t    q[$];
      prsl_pkg::out_beat_t    r;
      if (step == 0) step = 64'd1;
      s2   = {64'd0, step} * {64'd0, step};
      v[0] = longint'(b.in_x);
      v[1] = longint'(b.in_y);
      v[2] = longint'(b.in_z);
      if (!started) begin
        kept    = v;
        emitted = v;
        started = 1;
        emit(v, q);
      end else if (v != kept) begin
        if (dist_sq(emitted, v) > s2) begin
          if (kept == emitted) begin
            step_point(kept, v, emitted, 1, np);
            emitted = np;
            emit(np, q);
          end
          if (dist_sq(emitted, v) > s2) begin
            step_point(kept, v, emitted, 1, np);
            emitted = np;
            emit(np, q);
          end
        end
        kept = v;
      end
      if (b.final_vertex) begin
        if ((dist_sq(emitted, kept) << 2) > s2) begin
          step_point(emitted, kept, emitted, 0, np);
          emitted = np;
          emit(np, q);
        end
        if (q.size() == 0) begin
          r = '0;
          q = {q, r};
        end
        q[q.size() - 1].run_end = 1'b1;
        started = 0;
      end
      foreach (q[i]) pending_points = {pending_points, q[i]};
    endfunction

    task check_point(input prsl_pkg::out_beat_t got);
      prsl_pkg::out_beat_t exp;
      if (pending_points.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
        return;
      end
      exp = pending_points.pop_front();
      if (got.out_x !== exp.out_x)
        report($sformatf("out_x got %h exp %h", got.out_x, exp.out_x));
      if (got.out_y !== exp.out_y)
        report($sformatf("out_y got %h exp %h", got.out_y, exp.out_y));
      if (got.out_z !== exp.out_z)
        report($sformatf("out_z got %h exp %h", got.out_z, exp.out_z));
      if (got.point_valid !== exp.point_valid)
        report($sformatf("point_valid got %b exp %b", got.point_valid, exp.point_valid));
      if (got.run_end !== exp.run_end)
        report($sformatf("run_end got %b exp %b", got.run_end, exp.run_end));
    endtask
  endclass

  resample_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_vertex(input longint x, input longint y, input longint z,
                             input bit fin);
    int gap;
    gap = gappy ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push                 <= 1'b1;
    in_beat.in_x         <= prsl_pkg::coord_t'(x);
    in_beat.in_y         <= prsl_pkg::coord_t'(y);
    in_beat.in_z         <= prsl_pkg::coord_t'(z);
    in_beat.final_vertex <= fin;
    do @(posedge clk); while (full);
    sb.note_vertex(in_beat);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [prsl_pkg::STEP_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_step(v);
  endtask

  function automatic longint clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint wander(input longint base, input longint s);
    longint unsigned span;
    longint unsigned r;
    if ($urandom_range(0, 2) == 0) return base;
    span = 64'(s) * 3 + 1;
    r    = {$urandom, $urandom};
    return clamp32(base + longint'(r % span) - longint'(span / 2));
  endfunction

  task automatic random_polyline(input longint s);
    int     len;
    int     pick;
    longint px, py, pz;
    len = $urandom_range(1, 8);
    px  = longint'(signed'($urandom));
    py  = longint'(signed'($urandom));
    pz  = longint'(signed'($urandom));
    if ($urandom_range(0, 3) != 0) begin
      px = px >>> $urandom_range(4, 20);
      py = py >>> $urandom_range(4, 20);
      pz = pz >>> $urandom_range(4, 20);
    end
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (i > 0 && pick < 10) begin
      end else if (pick < 18) begin
        px = longint'(signed'($urandom));
        py = longint'(signed'($urandom));
        pz = longint'(signed'($urandom));
      end else begin
        px = wander(px, s);
        py = wander(py, s);
        pz = wander(pz, s);
      end
      send_vertex(px, py, pz, i == len - 1);
    end
  endtask

  initial begin
    logic [prsl_pkg::STEP_W-1:0] steps[8];
    int                          sent;
    sb       = new();
    n_errors = 0;
    gappy    = 1;
    rst_n    = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    in_beat  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_vertex(0, 0, 0, 0);
    send_vertex(0, 0, 0, 0);
    send_vertex(3 << 16, 0, 0, 0);
    send_vertex(3 << 16, 4 << 16, 0, 1);
    send_vertex(5 << 16, 5 << 16, 5 << 16, 1);
    send_vertex(1, 2, 3, 0);
    send_vertex(1, 2, 3, 1);
    send_vertex(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 0);
    send_vertex(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 0);
    send_vertex(64'sh7FFF_FFFF, -64'sh8000_0000, 0, 1);
    send_vertex(0, 0, 0, 0);
    send_vertex(10 << 16, 0, 0, 0);
    send_vertex(0, 1 << 15, 0, 0);
    send_vertex(-(10 << 16), 0, 0, 1);
    send_vertex(0, 0, 0, 0);
    send_vertex(3 << 15, 0, 0, 1);
    write_step('0);
    send_vertex(0, 0, 0, 0);
    send_vertex(5, -7, 2, 1);
    write_step({prsl_pkg::STEP_W{1'b1}});
    send_vertex(-64'sh8000_0000, 0, 0, 0);
    send_vertex(64'sh7FFF_FFFF, 0, 0, 1);

    steps = '{prsl_pkg::STEP_RESET, 31'd1, {prsl_pkg::STEP_W{1'b1}}, 31'd0, 31'h2AAA_AAAA,
              31'h5555_5555, 31'd300, 31'h0008_0000};
    foreach (steps[k]) begin
      write_step(steps[k]);
      gappy = (k % 3) != 2;
      sent  = 0;
      while (sent < 45) begin
        random_polyline((steps[k] == 0) ? 1 : longint'(steps[k]));
        sent += 4;
      end
    end

    drain();
    if (n_errors == 0 && sb.pending_points.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = gappy ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_point(out_beat);
    end
  end

endmodule

/* files.f */
design/prsl_pkg.sv
design/prsl_fifo.sv
design/prsl_arith.sv
design/prsl_back.sv
design/polyline_resample_by_step_length.sv
design/prsl_checker.sv
tb/tb_polyline_resample_by_step_length.sv
